[hw/rtl/ascending_score_sorter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ascending score sorter.
// Each macro checks an implication on the rising edge of the given clock,
// with the check held off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASCENDING_SCORE_SORTER_ASSERT_SVH
`define ASCENDING_SCORE_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared constants and types of the ascending score sorter.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int MAX_SCORES = 64;
    localparam int SCORE_W    = 16;
    localparam int ADDR_W     = $clog2(MAX_SCORES);
    // Count of stored scores, able to hold MAX_SCORES itself.
    localparam int CNT_W      = $clog2(MAX_SCORES + 1);
    // Pass position, which runs one beyond the count.
    localparam int POS_W      = $clog2(MAX_SCORES + 2);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_PASS,
        ST_OUT
    } sas_state_t;

endpackage

[hw/rtl/sas_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/ascending_score_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_score_sorter
// Collects a set of signed scores, bubble-sorts them in a RAM and streams
// them out in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Scores arrive on the s_ channel, one per transfer; s_tlast closes the set.
//   Up to MAX_SCORES (64) scores are stored; later ones of the same set are
//   discarded and m_tuser is then high on every result of that set.
//   After the closing transfer s_tready stays low while the set is sorted
//   and emitted.
//   Sorting runs passes over the score RAM, one entry per cycle through its
//   one read port and one write port; up to n passes are made over n
//   scores, and a set of one score skips the sort.
//   Results then leave on the m_ channel, a new RAM read waiting until the
//   data of the last one has reached the output register; m_tlast marks
//   the highest score. A stalled receiver simply holds the output register
//   and pauses the reads. After the last result the count and drop flag
//   clear.
//   Reset empties the set; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module ascending_score_sorter import sas_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] score
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sorted_score
    output logic        m_tlast,
    output logic        m_tuser    // [0] dropped
);

    sas_state_t          state_reg,    state_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic                overflow_reg, overflow_next;
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic                swap_reg,     swap_next;
    logic [SCORE_W-1:0]  hold_reg,     hold_next;
    logic [CNT_W-1:0]    out_idx_reg,  out_idx_next;
    logic                rd_pend_reg,  rd_pend_next;
    logic                m_valid_reg,  m_valid_next;
    logic [SCORE_W-1:0]  m_data_reg,   m_data_next;
    logic                m_last_reg,   m_last_next;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [SCORE_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [SCORE_W-1:0]  ram_rd_data;

    logic                s_fire;
    logic                m_fire;
    logic                store_full;
    logic [CNT_W-1:0]    fill_count;
    logic [POS_W-1:0]    pos_count;
    logic [POS_W-1:0]    pos_tail;
    logic [POS_W-1:0]    pos_wr;
    logic [CNT_W-1:0]    count_m1;
    logic                pos_tail_hit;
    logic                pos_cmp;
    logic                hold_greater;
    logic                out_issue;

    assign s_fire       = s_tvalid && s_tready;
    assign m_fire       = m_valid_reg && m_tready;
    assign store_full   = (count_reg == CNT_W'(MAX_SCORES));
    assign fill_count   = store_full ? count_reg : count_reg + CNT_W'(1);
    assign pos_count    = POS_W'(count_reg);
    assign pos_tail     = pos_count + POS_W'(1);
    assign pos_wr       = pos_reg - POS_W'(2);
    assign count_m1     = count_reg - CNT_W'(1);
    assign pos_tail_hit = (pos_reg == pos_tail);
    // A compare happens once the carried value is loaded and while data
    // from the run of reads is still arriving.
    assign pos_cmp      = (pos_reg >= POS_W'(2)) && (pos_reg <= pos_count);
    assign hold_greater = $signed(hold_reg) > $signed(ram_rd_data);
    assign out_issue    = (state_reg == ST_OUT) && (out_idx_reg < count_reg) &&
                          !rd_pend_reg && (!m_valid_reg || m_tready);

    sas_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_SCORES)
    ) u_score_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (s_fire && s_tlast) begin
                    state_next = (fill_count < CNT_W'(2)) ? ST_OUT : ST_PASS;
                end
            end
            ST_PASS: begin
                if (pos_tail_hit && !swap_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire && m_last_reg) begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // Handshake and RAM control.
    always_comb begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[ADDR_W-1:0];
        ram_wr_data = s_tdata;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        case (state_reg)
            ST_FILL: begin
                s_tready  = 1'b1;
                ram_wr_en = s_fire && !store_full;
            end
            ST_PASS: begin
                // Reads run two entries ahead of the writes, so a read and a write
                // never meet at the same entry.
                if (pos_reg < pos_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_reg[ADDR_W-1:0];
                end else if (pos_tail_hit && swap_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                end
                if (pos_cmp) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pos_wr[ADDR_W-1:0];
                    ram_wr_data = hold_greater ? ram_rd_data : hold_reg;
                end else if (pos_tail_hit) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = count_m1[ADDR_W-1:0];
                    ram_wr_data = hold_reg;
                end
            end
            ST_OUT: begin
                ram_rd_en   = out_issue;
                ram_rd_addr = out_idx_reg[ADDR_W-1:0];
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        pos_next      = pos_reg;
        swap_next     = swap_reg;
        hold_next     = hold_reg;
        out_idx_next  = out_idx_reg;
        rd_pend_next  = 1'b0;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            ST_FILL: begin
                pos_next     = '0;
                swap_next    = 1'b0;
                out_idx_next = '0;
                if (s_fire) begin
                    count_next = fill_count;
                    if (store_full) begin
                        overflow_next = 1'b1;
                    end
                end
            end
            ST_PASS: begin
                out_idx_next = '0;
                if (pos_tail_hit) begin
                    // A pass with a swap is followed by another one; its
                    // first read has already been issued.
                    pos_next  = POS_W'(1);
                    swap_next = 1'b0;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (pos_reg == POS_W'(1)) begin
                    hold_next = ram_rd_data;
                end else if (pos_cmp) begin
                    if (hold_greater) begin
                        swap_next = 1'b1;
                    end else begin
                        hold_next = ram_rd_data;
                    end
                end
            end
            ST_OUT: begin
                rd_pend_next = out_issue;
                if (out_issue) begin
                    out_idx_next = out_idx_reg + CNT_W'(1);
                end
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                    end
                end
                if (rd_pend_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rd_data;
                    m_last_next  = (out_idx_reg == count_reg);
                end
            end
            default: begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            pos_reg      <= '0;
            swap_reg     <= 1'b0;
            out_idx_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            pos_reg      <= pos_next;
            swap_reg     <= swap_next;
            out_idx_reg  <= out_idx_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = overflow_reg;

`include "ascending_score_sorter_assert.svh"

    `SAS_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_SCORES), "score count beyond store capacity")
    `SAS_ASSERT_SAME(a_read_lands_free, aclk, aresetn, rd_pend_reg, !m_valid_reg || m_tready, "read data arrives at an occupied output register")
    `SAS_ASSERT_SAME(a_last_after_all_reads, aclk, aresetn, m_valid_reg && m_last_reg, out_idx_reg == count_reg, "final result shown before all entries were read")
    `SAS_ASSERT_NEXT(a_set_clears, aclk, aresetn, m_fire && m_last_reg, count_reg == '0 && !overflow_reg, "set state not cleared after final result")

endmodule
